// File: hdl/route_waypoint_sync_table_core_macros.svh
// ----------------------------------------------------------------------------
// Route waypoint sync table - assertion macros
// Shared concurrent assertion forms for the route table core.
// ----------------------------------------------------------------------------
`ifndef ROUTE_WAYPOINT_SYNC_TABLE_CORE_MACROS_SVH
`define ROUTE_WAYPOINT_SYNC_TABLE_CORE_MACROS_SVH

// expression holds at every edge outside reset
`define RWST_ASSERT_HOLD(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RWST_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define RWST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/rwst_pkg.sv
// ----------------------------------------------------------------------------
// Route waypoint sync table - package
// Request codes, status codes and stream field layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rwst_pkg;

   typedef logic [2:0] action_type;
   typedef logic [1:0] status_type;

   localparam action_type ACT_BEGIN    = 3'd0;
   localparam action_type ACT_ADD_NAME = 3'd1;
   localparam action_type ACT_FINALIZE = 3'd2;
   localparam action_type ACT_ADD_COORD = 3'd3;
   localparam action_type ACT_READ     = 3'd4;

   localparam status_type STS_OK        = 2'd0;
   localparam status_type STS_FULL      = 2'd1;
   localparam status_type STS_SYNC      = 2'd2;
   localparam status_type STS_NOT_FOUND = 2'd3;

   localparam logic ROUTE_CURRENT_LEG = 1'b1;

   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;
   localparam int ID_W     = 16;
   localparam int NAME_W   = 64;
   localparam int LAT_W    = 31;
   localparam int LON_W    = 32;
   localparam int EIDX_W   = 4;
   localparam int SIZE_W   = 5;
   localparam int ORIG_W   = 4;

   // request tdata layout
   localparam int REQ_ID_LSB   = 0;
   localparam int REQ_NAME_LSB = REQ_ID_LSB + ID_W;
   localparam int REQ_TYPE_LSB = REQ_NAME_LSB + NAME_W;
   localparam int REQ_LAT_LSB  = REQ_TYPE_LSB + 1;
   localparam int REQ_LON_LSB  = REQ_LAT_LSB + LAT_W;
   localparam int REQ_EIDX_LSB = REQ_LON_LSB + LON_W;
   localparam int REQ_USED_W   = REQ_EIDX_LSB + EIDX_W;
   localparam int REQ_DATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   // response tdata layout
   localparam int RSP_USED_W = 1 + 1 + SIZE_W + SIZE_W + ORIG_W + ID_W + NAME_W + LAT_W + LON_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;

endpackage

// File: hdl/route_waypoint_sync_table_core.sv
// ----------------------------------------------------------------------------
// Route waypoint sync table core
// Stores one navigation route of waypoint names and coordinates, detects a
// repeated identical name sequence and locates the current leg origin.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tuser action, tdata route fields
//  rsp     | out | rsp_tvalid/rsp_tready | tuser status, tdata table state
//
//  One request at a time; a single table read port and one name comparator.
//  Begin, add, read and unused actions pass the fetch, execute and response states to the response register.
//  Finalize with an origin search repeats the fetch and execute states once per entry scanned, up to
//  MAX_WAYPOINTS entries.
//  Reset clears entry valid bits at once; no clearing pass is needed.
//  A waiting response does not block intake of the next request.
`timescale 1ns / 1ps
`include "route_waypoint_sync_table_core_macros.svh"

module route_waypoint_sync_table_core #(
   parameter int MAX_WAYPOINTS = 16,
   parameter int NAME_BYTES    = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // action
   input  logic [rwst_pkg::ACTION_W-1:0]   req_tuser,
   // route_id, waypoint_name, route_type, latitude, longitude, entry_index
   input  logic [rwst_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status
   output logic [rwst_pkg::STATUS_W-1:0]   rsp_tuser,
   // route_valid, same_as_previous, route_size, position, origin_index,
   // current_route_id, read_name, read_latitude, read_longitude
   output logic [rwst_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int PW = $clog2(MAX_WAYPOINTS + 1);
   localparam int NW = rwst_pkg::NAME_W;
   localparam int AW = rwst_pkg::LAT_W;
   localparam int OW = rwst_pkg::LON_W;

   typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_EXEC, ST_RESP} state_type;

   state_type                      state_ff, state_in;
   rwst_pkg::action_type           act_ff, act_in;
   logic [rwst_pkg::ID_W-1:0]      rid_ff, rid_in;
   logic [NW-1:0]                  name_ff, name_in;
   logic                           type_ff, type_in;
   logic [AW-1:0]                  lat_ff, lat_in;
   logic [OW-1:0]                  lon_ff, lon_in;
   logic [rwst_pkg::EIDX_W-1:0]    eidx_ff, eidx_in;
   logic [IW-1:0]                  addr_ff, addr_in;
   logic [PW-1:0]                  pos_ff, pos_in;
   logic [PW-1:0]                  size_ff, size_in;
   logic                           eq_ff, eq_in;
   logic                           vld_ff, vld_in;
   logic [IW-1:0]                  origin_ff, origin_in;
   logic [rwst_pkg::ID_W-1:0]      ident_ff, ident_in;
   rwst_pkg::status_type           sts_ff, sts_in;
   logic [NW-1:0]                  rdn_ff, rdn_in;
   logic [AW-1:0]                  rda_ff, rda_in;
   logic [OW-1:0]                  rdo_ff, rdo_in;
   logic                           rsp_vld_ff, rsp_vld_in;
   rwst_pkg::status_type           rsp_sts_ff, rsp_sts_in;
   logic [rwst_pkg::RSP_USED_W-1:0] rsp_dat_ff, rsp_dat_in;

   logic [NW-1:0] name_mem [MAX_WAYPOINTS];
   logic [AW-1:0] lat_mem  [MAX_WAYPOINTS];
   logic [OW-1:0] lon_mem  [MAX_WAYPOINTS];
   logic [MAX_WAYPOINTS-1:0] name_vld_ff;
   logic [MAX_WAYPOINTS-1:0] coord_vld_ff;
   logic [NW-1:0] mem_name_ff;
   logic [AW-1:0] mem_lat_ff;
   logic [OW-1:0] mem_lon_ff;
   logic          mem_nvld_ff;
   logic          mem_cvld_ff;

   logic          wr_name_en;
   logic          wr_coord_en;
   logic          req_fire;
   logic          rsp_free;
   logic          name_hit;
   logic          full;
   logic          eidx_ok;
   logic          req_eidx_ok;
   logic          req_full;
   logic [PW-1:0] next_addr;
   logic [NW-1:0] stored_name;

   function automatic logic names_match(logic [NW-1:0] stored, logic [NW-1:0] given);
      logic ok;
      logic live;
      ok   = 1'b1;
      live = 1'b1;
      for (int k = 0; k < 8; k++) begin
         if (k < NAME_BYTES && live) begin
            if (stored[8*k +: 8] != given[8*k +: 8]) begin
               ok   = 1'b0;
               live = 1'b0;
            end else if (stored[8*k +: 8] == 8'd0) begin
               live = 1'b0;
            end
         end
      end
      return ok;
   endfunction

   function automatic logic [NW-1:0] clean_name(logic [NW-1:0] given);
      logic [NW-1:0] r;
      logic          live;
      r    = '0;
      live = 1'b1;
      for (int k = 0; k < 8; k++) begin
         if (k < NAME_BYTES && live && given[8*k +: 8] != 8'd0) begin
            r[8*k +: 8] = given[8*k +: 8];
         end else begin
            live = 1'b0;
         end
      end
      return r;
   endfunction

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign rsp_free    = !rsp_vld_ff || rsp_tready;
   assign req_full    = (pos_ff >= PW'(MAX_WAYPOINTS));
   assign full        = req_full;
   assign req_eidx_ok = (32'(req_tdata[rwst_pkg::REQ_EIDX_LSB +: rwst_pkg::EIDX_W])
                         < MAX_WAYPOINTS);
   assign eidx_ok     = (32'(eidx_ff) < MAX_WAYPOINTS);
   assign stored_name = mem_nvld_ff ? mem_name_ff : '0;
   assign name_hit    = names_match(stored_name, name_ff);
   assign next_addr   = PW'(addr_ff) + PW'(1);

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      rid_in      = rid_ff;
      name_in     = name_ff;
      type_in     = type_ff;
      lat_in      = lat_ff;
      lon_in      = lon_ff;
      eidx_in     = eidx_ff;
      addr_in     = addr_ff;
      pos_in      = pos_ff;
      size_in     = size_ff;
      eq_in       = eq_ff;
      vld_in      = vld_ff;
      origin_in   = origin_ff;
      ident_in    = ident_ff;
      sts_in      = sts_ff;
      rdn_in      = rdn_ff;
      rda_in      = rda_ff;
      rdo_in      = rdo_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_sts_in  = rsp_sts_ff;
      rsp_dat_in  = rsp_dat_ff;
      wr_name_en  = 1'b0;
      wr_coord_en = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               act_in  = req_tuser;
               rid_in  = req_tdata[rwst_pkg::REQ_ID_LSB +: rwst_pkg::ID_W];
               name_in = req_tdata[rwst_pkg::REQ_NAME_LSB +: NW];
               type_in = req_tdata[rwst_pkg::REQ_TYPE_LSB];
               lat_in  = req_tdata[rwst_pkg::REQ_LAT_LSB +: AW];
               lon_in  = req_tdata[rwst_pkg::REQ_LON_LSB +: OW];
               eidx_in = req_tdata[rwst_pkg::REQ_EIDX_LSB +: rwst_pkg::EIDX_W];
               sts_in  = rwst_pkg::STS_OK;
               rdn_in  = '0;
               rda_in  = '0;
               rdo_in  = '0;
               addr_in = '0;
               if (req_tuser == rwst_pkg::ACT_READ && req_eidx_ok) begin
                  addr_in = IW'(req_tdata[rwst_pkg::REQ_EIDX_LSB +: rwst_pkg::EIDX_W]);
               end else if ((req_tuser == rwst_pkg::ACT_ADD_NAME ||
                             req_tuser == rwst_pkg::ACT_ADD_COORD) && !req_full) begin
                  addr_in = IW'(pos_ff);
               end
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
            case (act_ff)
               rwst_pkg::ACT_BEGIN: begin
                  ident_in = rid_ff;
                  eq_in    = 1'b1;
                  vld_in   = 1'b0;
                  size_in  = '0;
                  pos_in   = '0;
               end
               rwst_pkg::ACT_ADD_NAME: begin
                  if (full) begin
                     sts_in = rwst_pkg::STS_FULL;
                  end else begin
                     if (!eq_ff || !name_hit) begin
                        wr_name_en = 1'b1;
                        eq_in      = 1'b0;
                     end
                     pos_in = pos_ff + PW'(1);
                  end
               end
               rwst_pkg::ACT_FINALIZE: begin
                  if (type_ff == rwst_pkg::ROUTE_CURRENT_LEG && pos_ff != PW'(1)) begin
                     if (pos_ff == '0) begin
                        sts_in = rwst_pkg::STS_NOT_FOUND;
                     end else if (name_hit) begin
                        origin_in = addr_ff;
                     end else if (next_addr < pos_ff) begin
                        addr_in  = IW'(next_addr);
                        state_in = ST_FETCH;
                     end else begin
                        sts_in = rwst_pkg::STS_NOT_FOUND;
                     end
                  end else begin
                     origin_in = '0;
                  end
                  if (state_in == ST_RESP) begin
                     vld_in  = vld_ff || eq_ff;
                     size_in = pos_ff;
                     pos_in  = '0;
                  end
               end
               rwst_pkg::ACT_ADD_COORD: begin
                  if (full) begin
                     sts_in = rwst_pkg::STS_FULL;
                  end else if (name_hit) begin
                     wr_coord_en = 1'b1;
                     pos_in      = pos_ff + PW'(1);
                  end else begin
                     vld_in = 1'b0;
                     sts_in = rwst_pkg::STS_SYNC;
                  end
               end
               rwst_pkg::ACT_READ: begin
                  if (eidx_ok) begin
                     rdn_in = stored_name;
                     rda_in = mem_cvld_ff ? mem_lat_ff : '0;
                     rdo_in = mem_cvld_ff ? mem_lon_ff : '0;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_vld_in = 1'b1;
               rsp_sts_in = sts_ff;
               rsp_dat_in = {rdo_ff, rda_ff, rdn_ff, ident_ff,
                             rwst_pkg::ORIG_W'(origin_ff),
                             rwst_pkg::SIZE_W'(pos_ff),
                             rwst_pkg::SIZE_W'(size_ff), eq_ff, vld_ff};
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pos_ff     <= '0;
         size_ff    <= '0;
         eq_ff      <= 1'b1;
         vld_ff     <= 1'b0;
         origin_ff  <= '0;
         ident_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         size_ff    <= size_in;
         eq_ff      <= eq_in;
         vld_ff     <= vld_in;
         origin_ff  <= origin_in;
         ident_ff   <= ident_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      act_ff     <= act_in;
      rid_ff     <= rid_in;
      name_ff    <= name_in;
      type_ff    <= type_in;
      lat_ff     <= lat_in;
      lon_ff     <= lon_in;
      eidx_ff    <= eidx_in;
      addr_ff    <= addr_in;
      sts_ff     <= sts_in;
      rdn_ff     <= rdn_in;
      rda_ff     <= rda_in;
      rdo_ff     <= rdo_in;
      rsp_sts_ff <= rsp_sts_in;
      rsp_dat_ff <= rsp_dat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_vld_ff  <= '0;
         coord_vld_ff <= '0;
      end else begin
         if (wr_name_en) begin
            name_vld_ff[addr_ff] <= 1'b1;
         end
         if (wr_coord_en) begin
            coord_vld_ff[addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_name_en) begin
         name_mem[addr_ff] <= clean_name(name_ff);
      end
      if (wr_coord_en) begin
         lat_mem[addr_ff] <= lat_ff;
         lon_mem[addr_ff] <= lon_ff;
      end
      if (state_ff == ST_FETCH) begin
         mem_name_ff <= name_mem[addr_ff];
         mem_lat_ff  <= lat_mem[addr_ff];
         mem_lon_ff  <= lon_mem[addr_ff];
         mem_nvld_ff <= name_vld_ff[addr_ff];
         mem_cvld_ff <= coord_vld_ff[addr_ff];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_sts_ff;
   assign rsp_tdata  = rwst_pkg::RSP_DATA_W'(rsp_dat_ff);

   `RWST_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready, "request taken while busy")
   `RWST_ASSERT_HOLD(a_pos_in_range, clock, reset, pos_ff <= PW'(MAX_WAYPOINTS), "position beyond table")
   `RWST_ASSERT_SAME(a_search_in_range, clock, reset, state_ff == ST_EXEC && act_ff == rwst_pkg::ACT_FINALIZE && type_ff == rwst_pkg::ROUTE_CURRENT_LEG && pos_ff > PW'(1), PW'(addr_ff) < pos_ff, "origin search past received names")
   `RWST_ASSERT_NEXT(a_rsp_loaded, clock, reset, state_ff == ST_RESP && rsp_free, rsp_tvalid && req_tready, "response not loaded")

endmodule
